/* sv/sigmoid_activation_unit_core_assert.svh */
// Assertion macros used by the sigmoid unit checker
`ifndef SIGMOID_ACTIVATION_UNIT_CORE_ASSERT_SVH
`define SIGMOID_ACTIVATION_UNIT_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is held
`define SAU_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held
`define SAU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also runs during reset
`define SAU_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/sau_pkg.sv */
// Shared types and constants of the sigmoid activation unit
`default_nettype none

package sau_pkg;

    // Fixed-point format of operand and result
    localparam int DATA_W = 16;
    localparam int FRAC_W = 12;

    // Sigmoid result width: 0 .. 2^FRAC_W
    localparam int S_W = FRAC_W + 1;

    // Q60 word for the exponential, and width of the scaled product
    localparam int ACC_W = 61;
    localparam int Q_W   = 60;

    // Series terms past the 13th are zero for |x| <= 8 (y <= 0.25)
    localparam int TAYLOR_TERMS = 13;
    localparam int SQUARINGS    = 5;

    // Operation codes
    localparam logic [1:0] OP_SIGMOID   = 2'd0;
    localparam logic [1:0] OP_DERIV_IN  = 2'd1;
    localparam logic [1:0] OP_DERIV_OUT = 2'd2;
    localparam logic [1:0] OP_RESERVED  = 2'd3;

    // Saturation bounds
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef logic [ACC_W-1:0] t_q60;

    localparam t_q60 ONE_Q60 = {1'b1, {(ACC_W-1){1'b0}}};

    // Sideband that travels with each request through the pipeline
    typedef struct packed {
        logic                     valid;
        logic [1:0]               op;
        logic signed [DATA_W-1:0] x;
        logic                     last;
    } t_side;

endpackage

`default_nettype wire

/* sv/sau_series.sv */
// Taylor series of exp(-|x|/32) in Q60, three stages per term
`default_nettype none

module sau_series (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  sau_pkg::t_side i_side,
    output sau_pkg::t_side o_side,
    output sau_pkg::t_q60  o_sum
);

    localparam int TERMS    = sau_pkg::TAYLOR_TERMS;
    localparam int PROD_W   = sau_pkg::ACC_W + sau_pkg::DATA_W;
    localparam int Y_SHIFT  = sau_pkg::FRAC_W + 5;
    localparam bit LAST_NEG = (TERMS % 2) == 1;

    // Term-done stage (index 0 is the entry stage)
    sau_pkg::t_side              r_c_side [0:TERMS];
    logic [sau_pkg::DATA_W-1:0]  r_c_t    [0:TERMS];
    sau_pkg::t_q60               r_c_term [0:TERMS];
    sau_pkg::t_q60               r_c_sum  [0:TERMS];

    // Product stage
    sau_pkg::t_side              r_a_side [1:TERMS];
    logic [sau_pkg::DATA_W-1:0]  r_a_t    [1:TERMS];
    logic [sau_pkg::Q_W-1:0]     r_a_q    [1:TERMS];
    sau_pkg::t_q60               r_a_sum  [1:TERMS];

    // Reciprocal partial-product stage
    sau_pkg::t_side              r_b_side [1:TERMS];
    logic [sau_pkg::DATA_W-1:0]  r_b_t    [1:TERMS];
    sau_pkg::t_q60               r_b_sum  [1:TERMS];
    logic [60:0]                 r_b_p00  [1:TERMS];
    logic [59:0]                 r_b_p01  [1:TERMS];
    logic [60:0]                 r_b_p10  [1:TERMS];
    logic [59:0]                 r_b_p11  [1:TERMS];

    sau_pkg::t_side              r_f_side;
    sau_pkg::t_q60               r_f_sum;

    logic [sau_pkg::DATA_W-1:0]  n_t0;
    sau_pkg::t_q60               n_f_sum;

    // Entry: t = |x|, at most 8.0 for a 16-bit Q4.12 operand
    assign n_t0 = i_side.x[sau_pkg::DATA_W-1] ? sau_pkg::DATA_W'(-i_side.x)
                                              : sau_pkg::DATA_W'(i_side.x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_side[0].valid <= 1'b0;
        end else if (i_en) begin
            r_c_side[0] <= i_side;
            r_c_t[0]    <= n_t0;
            r_c_term[0] <= sau_pkg::ONE_Q60;
            r_c_sum[0]  <= '0;
        end
    end

    for (genvar k = 1; k <= TERMS; k++) begin : g_term
        localparam int           N          = k;
        localparam int           L          = $clog2(N);
        localparam logic [127:0] RECIP_FULL = ((128'd1 << (60 + L)) + 128'(N) - 128'd1) / N;
        localparam logic [60:0]  RECIP      = RECIP_FULL[60:0];
        localparam bit           NEG        = ((N - 1) % 2) == 1;

        logic [PROD_W-1:0] n_prod;
        sau_pkg::t_q60     n_sum;
        logic [127:0]      n_full;

        // term * y >> 60 == term * t >> 17; fold the previous term into the sum
        assign n_prod = {{sau_pkg::DATA_W{1'b0}}, r_c_term[k-1]}
                      * {{sau_pkg::ACC_W{1'b0}}, r_c_t[k-1]};
        assign n_sum  = NEG ? (r_c_sum[k-1] - r_c_term[k-1])
                            : (r_c_sum[k-1] + r_c_term[k-1]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_side[k].valid <= 1'b0;
            end else if (i_en) begin
                r_a_side[k] <= r_c_side[k-1];
                r_a_t[k]    <= r_c_t[k-1];
                r_a_q[k]    <= n_prod[PROD_W-1:Y_SHIFT];
                r_a_sum[k]  <= n_sum;
            end
        end

        // Divide by n: q * ceil(2^(60+L)/n) >> (60+L), split in four partials
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_b_side[k].valid <= 1'b0;
            end else if (i_en) begin
                r_b_side[k] <= r_a_side[k];
                r_b_t[k]    <= r_a_t[k];
                r_b_sum[k]  <= r_a_sum[k];
                r_b_p00[k]  <= {31'd0, r_a_q[k][29:0]}  * {30'd0, RECIP[30:0]};
                r_b_p01[k]  <= {30'd0, r_a_q[k][29:0]}  * {30'd0, RECIP[60:31]};
                r_b_p10[k]  <= {31'd0, r_a_q[k][59:30]} * {30'd0, RECIP[30:0]};
                r_b_p11[k]  <= {30'd0, r_a_q[k][59:30]} * {30'd0, RECIP[60:31]};
            end
        end

        assign n_full = 128'(r_b_p00[k])
                      + (128'(r_b_p01[k]) << 31)
                      + (128'(r_b_p10[k]) << 30)
                      + (128'(r_b_p11[k]) << 61);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c_side[k].valid <= 1'b0;
            end else if (i_en) begin
                r_c_side[k] <= r_b_side[k];
                r_c_t[k]    <= r_b_t[k];
                r_c_sum[k]  <= r_b_sum[k];
                r_c_term[k] <= n_full[60 + L +: sau_pkg::ACC_W];
            end
        end
    end

    // Fold in the last term
    assign n_f_sum = LAST_NEG ? (r_c_sum[TERMS] - r_c_term[TERMS])
                              : (r_c_sum[TERMS] + r_c_term[TERMS]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_side.valid <= 1'b0;
        end else if (i_en) begin
            r_f_side <= r_c_side[TERMS];
            r_f_sum  <= n_f_sum;
        end
    end

    assign o_side = r_f_side;
    assign o_sum  = r_f_sum;

endmodule

`default_nettype wire

/* sv/sau_square.sv */
// Five Q60 squarings that turn exp(-t/32) into exp(-t), two stages each
`default_nettype none

module sau_square (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  sau_pkg::t_side i_side,
    input  sau_pkg::t_q60  i_val,
    output sau_pkg::t_side o_side,
    output sau_pkg::t_q60  o_val
);

    localparam int SQ = sau_pkg::SQUARINGS;

    sau_pkg::t_side w_side [0:SQ];
    sau_pkg::t_q60  w_val  [0:SQ];

    sau_pkg::t_side r_p_side [0:SQ-1];
    logic [61:0]    r_p_ll   [0:SQ-1];
    logic [60:0]    r_p_lh   [0:SQ-1];
    logic [59:0]    r_p_hh   [0:SQ-1];

    sau_pkg::t_side r_s_side [0:SQ-1];
    sau_pkg::t_q60  r_s_val  [0:SQ-1];

    assign w_side[0] = i_side;
    assign w_val[0]  = i_val;

    for (genvar j = 0; j < SQ; j++) begin : g_sq
        logic [127:0] n_full;

        // a = hi*2^31 + lo; a^2 = lo^2 + 2*lo*hi*2^31 + hi^2*2^62
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_p_side[j].valid <= 1'b0;
            end else if (i_en) begin
                r_p_side[j] <= w_side[j];
                r_p_ll[j]   <= {31'd0, w_val[j][30:0]}  * {31'd0, w_val[j][30:0]};
                r_p_lh[j]   <= {30'd0, w_val[j][30:0]}  * {31'd0, w_val[j][60:31]};
                r_p_hh[j]   <= {30'd0, w_val[j][60:31]} * {30'd0, w_val[j][60:31]};
            end
        end

        assign n_full = 128'(r_p_ll[j])
                      + (128'(r_p_lh[j]) << 32)
                      + (128'(r_p_hh[j]) << 62);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s_side[j].valid <= 1'b0;
            end else if (i_en) begin
                r_s_side[j] <= r_p_side[j];
                r_s_val[j]  <= n_full[60 +: sau_pkg::ACC_W];
            end
        end

        assign w_side[j+1] = r_s_side[j];
        assign w_val[j+1]  = r_s_val[j];
    end

    assign o_side = w_side[SQ];
    assign o_val  = w_val[SQ];

endmodule

`default_nettype wire

/* sv/sau_div.sv */
// Sigmoid quotient: restoring division, one quotient bit per stage
`default_nettype none

module sau_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  sau_pkg::t_side          i_side,
    input  sau_pkg::t_q60           i_e,
    output sau_pkg::t_side          o_side,
    output logic [sau_pkg::S_W-1:0] o_s
);

    localparam int SW    = sau_pkg::S_W;
    localparam int NUM_W = 55;
    localparam int DEN_W = 43;

    sau_pkg::t_side     r_side [0:SW];
    logic [NUM_W-1:0]   r_rem  [0:SW];
    logic [DEN_W-1:0]   r_den  [0:SW];
    logic [SW-1:0]      r_q    [0:SW];

    logic [40:0]        n_e40;
    logic [41:0]        n_d;
    logic [NUM_W-1:0]   n_num;

    // D = 2^40 + e40; numerator by sign of x, denominator 2D
    assign n_e40 = i_e[60:20];
    assign n_d   = {1'b0, n_e40} + (42'd1 << 40);
    assign n_num = i_side.x[sau_pkg::DATA_W-1]
                 ? (NUM_W'({n_e40, {(sau_pkg::FRAC_W+1){1'b0}}}) + NUM_W'(n_d))
                 : ((NUM_W'(1) << (41 + sau_pkg::FRAC_W)) + NUM_W'(n_d));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side[0].valid <= 1'b0;
        end else if (i_en) begin
            r_side[0] <= i_side;
            r_rem[0]  <= n_num;
            r_den[0]  <= {n_d, 1'b0};
            r_q[0]    <= '0;
        end
    end

    for (genvar g = 0; g < SW; g++) begin : g_bit
        localparam int B = SW - 1 - g;

        logic [NUM_W:0] n_diff;

        assign n_diff = {1'b0, r_rem[g]} - ((NUM_W+1)'(r_den[g]) << B);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[g+1].valid <= 1'b0;
            end else if (i_en) begin
                r_side[g+1] <= r_side[g];
                r_den[g+1]  <= r_den[g];
                if (!n_diff[NUM_W]) begin
                    r_rem[g+1] <= n_diff[NUM_W-1:0];
                    r_q[g+1]   <= {r_q[g][SW-2:0], 1'b1};
                end else begin
                    r_rem[g+1] <= r_rem[g];
                    r_q[g+1]   <= {r_q[g][SW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_side = r_side[SW];
    assign o_s    = r_q[SW];

endmodule

`default_nettype wire

/* sv/sau_post.sv */
// Derivative product, rounding, saturation and the output register
`default_nettype none

module sau_post (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  sau_pkg::t_side                 i_side,
    input  logic [sau_pkg::S_W-1:0]        i_s,
    output logic                           o_valid,
    output logic signed [sau_pkg::DATA_W-1:0] o_value,
    output logic                           o_saturated,
    output logic                           o_last_out
);

    localparam int AW = sau_pkg::DATA_W + 1;
    localparam int BW = sau_pkg::DATA_W + 2;
    localparam int PW = AW + BW;
    localparam int RW = PW - sau_pkg::FRAC_W;

    sau_pkg::t_side              r_side;
    logic [sau_pkg::S_W-1:0]     r_s;
    logic signed [PW-1:0]        r_p;

    logic                           r_out_valid;
    logic signed [sau_pkg::DATA_W-1:0] r_out_value;
    logic                           r_out_sat;
    logic                           r_out_last;

    logic signed [AW-1:0]        n_a;
    logic signed [BW-1:0]        n_b;
    logic signed [PW-1:0]        n_p;
    logic signed [PW-1:0]        n_rnd;
    logic signed [RW-1:0]        n_r;
    logic signed [sau_pkg::DATA_W-1:0] n_value;
    logic                           n_sat;

    // a * (1 - a), with a the sigmoid or the operand itself
    always_comb begin
        if (i_side.op == sau_pkg::OP_DERIV_IN) begin
            n_a = $signed(AW'(i_s));
        end else begin
            n_a = AW'($signed(i_side.x));
        end
        n_b = (BW'(1) <<< sau_pkg::FRAC_W) - BW'(n_a);
        n_p = PW'(n_a) * PW'(n_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side <= i_side;
            r_s    <= i_s;
            r_p    <= n_p;
        end
    end

    // Round to nearest (ties up), saturate, select by operation
    always_comb begin
        n_rnd   = r_p + (PW'(1) <<< (sau_pkg::FRAC_W - 1));
        n_r     = $signed(n_rnd[PW-1:sau_pkg::FRAC_W]);
        n_value = '0;
        n_sat   = 1'b0;
        case (r_side.op)
            sau_pkg::OP_SIGMOID: begin
                n_value = sau_pkg::DATA_W'(r_s);
            end
            sau_pkg::OP_DERIV_IN, sau_pkg::OP_DERIV_OUT: begin
                if (n_r > RW'(sau_pkg::VAL_MAX)) begin
                    n_value = sau_pkg::VAL_MAX;
                    n_sat   = 1'b1;
                end else if (n_r < RW'(sau_pkg::VAL_MIN)) begin
                    n_value = sau_pkg::VAL_MIN;
                    n_sat   = 1'b1;
                end else begin
                    n_value = n_r[sau_pkg::DATA_W-1:0];
                end
            end
            default: begin
                n_value = '0;
                n_sat   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= r_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_value <= n_value;
            r_out_sat   <= n_sat;
            r_out_last  <= r_side.last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_value     = r_out_value;
    assign o_saturated = r_out_sat;
    assign o_last_out  = r_out_last;

endmodule

`default_nettype wire

/* sv/sigmoid_activation_unit_core.sv */
// Top level of the sigmoid activation unit: pipeline control and datapath
//
// Usage: one request per cycle, while o_stall is low, on the input channel (i_valid / o_stall)
// carries an operation code, a signed Q4.12 operand and a last marker.
// Operation 0 returns the logistic sigmoid, 1 the derivative s*(1-s) of the
// sigmoid of the operand, 2 the derivative x*(1-x) of an earlier sigmoid
// result x; code 3 returns zero. Each request gives exactly one result on
// the output channel (o_valid / i_stall), in request order.
// Pipeline: 67 register stages, 41 in the series (entry, three per term
// for 13 terms, final fold), 10 for five squarings, 14 in the divider
// (entry plus one per quotient bit) and 2 in the output stage.
// Throughput: one request per cycle while no stalled result holds the
// pipeline; every stage then takes a new request and nothing iterates.
// Backpressure: while a result waits and i_stall is high, the whole
// pipeline holds and o_stall is raised; empty slots still travel as
// bubbles, so nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) clears all valid bits; data registers
// are not reset.
`default_nettype none

module sigmoid_activation_unit_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_operation,
    input  logic signed [sau_pkg::DATA_W-1:0] i_operand,
    input  logic                              i_last_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [sau_pkg::DATA_W-1:0] o_value,
    output logic                              o_saturated,
    output logic                              o_last_out
);

    logic                    w_en;
    sau_pkg::t_side          w_in_side;
    sau_pkg::t_side          w_ser_side;
    sau_pkg::t_q60           w_ser_sum;
    sau_pkg::t_side          w_sq_side;
    sau_pkg::t_q60           w_sq_val;
    sau_pkg::t_side          w_div_side;
    logic [sau_pkg::S_W-1:0] w_div_s;

    // Pipeline advances unless a held result is being stalled
    assign o_stall = o_valid & i_stall;
    assign w_en    = ~o_stall;

    always_comb begin
        w_in_side.valid = i_valid;
        w_in_side.op    = i_operation;
        w_in_side.x     = i_operand;
        w_in_side.last  = i_last_in;
    end

    sau_series u_series (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_side  (w_in_side),
        .o_side  (w_ser_side),
        .o_sum   (w_ser_sum)
    );

    sau_square u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_side  (w_ser_side),
        .i_val   (w_ser_sum),
        .o_side  (w_sq_side),
        .o_val   (w_sq_val)
    );

    sau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_side  (w_sq_side),
        .i_e     (w_sq_val),
        .o_side  (w_div_side),
        .o_s     (w_div_s)
    );

    sau_post u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_side      (w_div_side),
        .i_s         (w_div_s),
        .o_valid     (o_valid),
        .o_value     (o_value),
        .o_saturated (o_saturated),
        .o_last_out  (o_last_out)
    );

endmodule

`default_nettype wire

/* sv/sau_checker.sv */
// Port-level checker for the sigmoid activation unit, bound to the top level
`default_nettype none

`include "sigmoid_activation_unit_core_assert.svh"

module sau_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_stall,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic signed [sau_pkg::DATA_W-1:0] o_value,
    input logic                              o_saturated
);

    // Reset empties the output register
    `SAU_ASSERT_RST(a_reset_clears, !i_rst_n, !o_valid, "result valid after reset")

    // A stalled result stays put
    `SAU_ASSERT_NXT(a_hold_stalled, o_valid && i_stall, o_valid && $stable(o_value) && $stable(o_saturated), "stalled result changed")

    // Input backpressure only while a result is held
    `SAU_ASSERT(a_stall_only_held, o_stall, o_valid && i_stall, "input stalled without held result")

    // Saturated results sit on a bound
    `SAU_ASSERT(a_sat_on_bound, o_valid && o_saturated, o_value == sau_pkg::VAL_MAX || o_value == sau_pkg::VAL_MIN, "saturated value off bound")

endmodule

bind sigmoid_activation_unit_core sau_checker u_sau_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_stall     (i_stall),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .o_value     (o_value),
    .o_saturated (o_saturated)
);

`default_nettype wire
